>>> design/tf_pkg.sv
// Shared types, sizes and helpers for the triangle tangent frame block.
// Used by every module of the block but tf_ram; depends on nothing.
package tf_pkg;

  localparam int POS_DEPTH = 4096;
  localparam int TEX_DEPTH = 4096;
  localparam int NRM_DEPTH = 4096;

  localparam int POS_AW = (POS_DEPTH > 1) ? $clog2(POS_DEPTH) : 1;
  localparam int TEX_AW = (TEX_DEPTH > 1) ? $clog2(TEX_DEPTH) : 1;
  localparam int NRM_AW = (NRM_DEPTH > 1) ? $clog2(NRM_DEPTH) : 1;
  localparam int POS_CW = $clog2(POS_DEPTH + 1);
  localparam int TEX_CW = $clog2(TEX_DEPTH + 1);
  localparam int NRM_CW = $clog2(NRM_DEPTH + 1);

  localparam int IDX_W = 13;
  localparam int CW_MAX = (POS_CW > TEX_CW) ? ((POS_CW > NRM_CW) ? POS_CW : NRM_CW)
                                            : ((TEX_CW > NRM_CW) ? TEX_CW : NRM_CW);
  localparam int CMP_W = (CW_MAX > IDX_W) ? CW_MAX : IDX_W;

  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW = $clog2(CQ_DEPTH);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW = $clog2(OQ_DEPTH);

  localparam logic [2:0] MODE_POS = 3'd0;
  localparam logic [2:0] MODE_TEX = 3'd1;
  localparam logic [2:0] MODE_NRM = 3'd2;
  localparam logic [2:0] MODE_TRI = 3'd3;
  localparam logic [2:0] MODE_CLR = 3'd4;

  typedef enum logic [1:0] {OP_POS, OP_TEX, OP_NRM, OP_TRI} op_t;

  // element 0 is x, 1 is y, 2 is z
  typedef logic [2:0][31:0] svec_t;
  typedef logic [2:0][63:0] wvec_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [12:0]       position_number;
    logic [12:0]       texcoord_number;
    logic [12:0]       normal_number;
  } in_t;

  typedef struct packed {
    logic [1:0]        corner;
    logic              last;
    logic              index_fault;
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic signed [31:0] bitangent_x;
    logic signed [31:0] bitangent_y;
    logic signed [31:0] bitangent_z;
  } out_t;

  // One queued work entry. Loads use index 0 of the matching table address.
  typedef struct packed {
    op_t                    op;
    svec_t                  vec;
    logic [2:0][POS_AW-1:0] pidx;
    logic [2:0][TEX_AW-1:0] tidx;
    logic [2:0][NRM_AW-1:0] nidx;
    logic                   geom_ok;
    logic [2:0]             nok;
    logic                   fault;
  } cmd_t;

  typedef struct packed {
    logic start;
    logic scale_only;
  } norm_req_t;

  function automatic logic [31:0] sat31(input logic [32:0] d);
    logic [31:0] r;
    r = d[31:0];
    if (!d[32] && d[31]) r = 32'h7FFF_FFFF;
    else if (d[32] && (d[31:0] <= 32'h8000_0000)) r = 32'h8000_0001;
    return r;
  endfunction

  function automatic logic [31:0] diff31(input logic [31:0] a, input logic [31:0] b);
    return sat31({a[31], a} - {b[31], b});
  endfunction

  function automatic logic idx_ok(input logic [IDX_W-1:0] idx, input logic [CMP_W-1:0] cnt);
    return (idx != '0) && (CMP_W'(idx) <= cnt);
  endfunction

endpackage

>>> design/tf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> design/tf_norm.sv
// Shared vector normalize unit: prescale, sum of squares, square root, divide; or prescale only.
// Depends on tf_pkg.
module tf_norm import tf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  norm_req_t req,
  input  wvec_t     vec,
  output logic      done,
  output svec_t     res
);

  typedef enum logic [2:0] {N_IDLE, N_SCALE, N_SQ, N_ROOT, N_PREP, N_DIV} nstate_t;

  nstate_t          state;
  logic             scale;
  logic [2:0]       neg;
  wvec_t            mag;
  logic [4:0]       cnt;
  logic [61:0]      sqp;
  logic [63:0]      sum;
  logic [63:0]      x;
  logic [63:0]      r;
  logic [63:0]      b;
  logic [31:0]      len;
  logic [2:0][17:0] num;
  logic [2:0][32:0] rem;
  logic [2:0][17:0] q;

  logic [63:0]      m;
  logic [63:0]      rb;
  logic [2:0][47:0] nsum;
  logic [2:0][32:0] dt;
  logic [2:0][32:0] rem_next;
  logic [2:0][17:0] q_next;

  always_comb begin
    m = mag[0];
    if (mag[1] > m) m = mag[1];
    if (mag[2] > m) m = mag[2];
    rb = r + b;
    for (int i = 0; i < 3; i++) begin
      nsum[i] = {1'b0, mag[i][30:0], 16'b0} + {17'b0, r[31:1]};
      dt[i] = {rem[i][31:0], num[i][17]};
      if (dt[i] >= {1'b0, len}) begin
        rem_next[i] = dt[i] - {1'b0, len};
        q_next[i] = {q[i][16:0], 1'b1};
      end else begin
        rem_next[i] = dt[i];
        q_next[i] = {q[i][16:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        N_IDLE: begin
          if (req.start) begin
            scale <= req.scale_only;
            for (int i = 0; i < 3; i++) begin
              neg[i] <= vec[i][63];
              mag[i] <= vec[i][63] ? (64'd0 - vec[i]) : vec[i];
            end
            state <= N_SCALE;
          end
        end
        N_SCALE: begin
          // coarse steps of 8 bits, then single bits, into [2^30, 2^31)
          if (m == '0) begin
            res <= '0;
            done <= 1'b1;
            state <= N_IDLE;
          end else if (m[63:39] != '0) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 8;
          end else if (m[63:31] != '0) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else if (m[63:22] == '0) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 8;
          end else if (!m[30]) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
          end else if (scale) begin
            for (int i = 0; i < 3; i++)
              res[i] <= neg[i] ? (32'd0 - mag[i][31:0]) : mag[i][31:0];
            done <= 1'b1;
            state <= N_IDLE;
          end else begin
            cnt <= '0;
            sum <= '0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          if (cnt != 5'd3) sqp <= mag[cnt[1:0]][30:0] * mag[cnt[1:0]][30:0];
          if (cnt != 5'd0) sum <= sum + {2'b0, sqp};
          if (cnt == 5'd3) begin
            x <= sum + {2'b0, sqp};
            r <= '0;
            b <= 64'h4000_0000_0000_0000;
            cnt <= '0;
            state <= N_ROOT;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        N_ROOT: begin
          if (x >= rb) begin
            x <= x - rb;
            r <= (r >> 1) + b;
          end else begin
            r <= r >> 1;
          end
          b <= b >> 2;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) state <= N_PREP;
        end
        N_PREP: begin
          len <= r[31:0];
          for (int i = 0; i < 3; i++) begin
            rem[i] <= {3'b0, nsum[i][47:18]};
            num[i] <= nsum[i][17:0];
            q[i] <= '0;
          end
          cnt <= '0;
          state <= N_DIV;
        end
        N_DIV: begin
          for (int i = 0; i < 3; i++) begin
            rem[i] <= rem_next[i];
            q[i] <= q_next[i];
            num[i] <= {num[i][16:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd17) begin
            for (int i = 0; i < 3; i++)
              res[i] <= neg[i] ? (32'd0 - {14'b0, q_next[i]}) : {14'b0, q_next[i]};
            done <= 1'b1;
            state <= N_IDLE;
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

endmodule

>>> design/tf_front.sv
// Front end: accepts items, keeps table counts and held corners, checks
// indices and queues load and triangle work. Depends on tf_pkg.
module tf_front import tf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  item,
  output logic cmd_valid,
  output cmd_t cmd,
  input  logic cmd_pop
);

  logic [POS_CW-1:0]         pos_count;
  logic [TEX_CW-1:0]         tex_count;
  logic [NRM_CW-1:0]         nrm_count;
  logic [1:0]                held;
  logic [1:0][IDX_W-1:0]     cp;
  logic [1:0][IDX_W-1:0]     ct;
  logic [1:0][IDX_W-1:0]     cn;

  cmd_t                      q [CQ_DEPTH];
  logic [CQ_AW-1:0]          wp;
  logic [CQ_AW-1:0]          rp;
  logic [CQ_AW:0]            qn;

  logic                      accept;
  logic                      q_push;
  cmd_t                      ncmd;

  assign full = (qn == (CQ_AW+1)'(CQ_DEPTH));
  assign cmd_valid = (qn != '0);
  assign cmd = q[rp];
  assign accept = push && !full;

  always_comb begin
    logic [2:0][IDX_W-1:0] pn, tn, nn;
    logic [CMP_W-1:0] pd, td, nd;
    logic pv, tv, nv;
    pn = {item.position_number, cp[1], cp[0]};
    tn = {item.texcoord_number, ct[1], ct[0]};
    nn = {item.normal_number, cn[1], cn[0]};
    pd = '0;
    td = '0;
    nd = '0;
    pv = 1'b0;
    tv = 1'b0;
    nv = 1'b0;
    q_push = 1'b0;
    ncmd = '0;
    ncmd.vec = {item.coord_z, item.coord_y, item.coord_x};
    ncmd.geom_ok = 1'b1;
    case (item.mode)
      MODE_POS: begin
        ncmd.op = OP_POS;
        ncmd.pidx[0] = pos_count[POS_AW-1:0];
        q_push = accept && (pos_count != POS_CW'(POS_DEPTH));
      end
      MODE_TEX: begin
        ncmd.op = OP_TEX;
        ncmd.tidx[0] = tex_count[TEX_AW-1:0];
        q_push = accept && (tex_count != TEX_CW'(TEX_DEPTH));
      end
      MODE_NRM: begin
        ncmd.op = OP_NRM;
        ncmd.nidx[0] = nrm_count[NRM_AW-1:0];
        q_push = accept && (nrm_count != NRM_CW'(NRM_DEPTH));
      end
      MODE_TRI: begin
        ncmd.op = OP_TRI;
        q_push = accept && (held == 2'd2);
        for (int k = 0; k < 3; k++) begin
          pv = idx_ok(pn[k], CMP_W'(pos_count));
          tv = idx_ok(tn[k], CMP_W'(tex_count));
          nv = idx_ok(nn[k], CMP_W'(nrm_count));
          pd = CMP_W'(pn[k]) - CMP_W'(1);
          td = CMP_W'(tn[k]) - CMP_W'(1);
          nd = CMP_W'(nn[k]) - CMP_W'(1);
          ncmd.pidx[k] = pv ? pd[POS_AW-1:0] : '0;
          ncmd.tidx[k] = tv ? td[TEX_AW-1:0] : '0;
          ncmd.nidx[k] = nv ? nd[NRM_AW-1:0] : '0;
          ncmd.nok[k] = nv;
          if (!(pv && tv)) ncmd.geom_ok = 1'b0;
          if (!(pv && tv && nv)) ncmd.fault = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_count <= '0;
      tex_count <= '0;
      nrm_count <= '0;
      held <= '0;
      wp <= '0;
      rp <= '0;
      qn <= '0;
    end else begin
      if (accept) begin
        case (item.mode)
          MODE_POS: if (q_push) pos_count <= pos_count + POS_CW'(1);
          MODE_TEX: if (q_push) tex_count <= tex_count + TEX_CW'(1);
          MODE_NRM: if (q_push) nrm_count <= nrm_count + NRM_CW'(1);
          MODE_TRI: held <= (held == 2'd2) ? 2'd0 : held + 2'd1;
          MODE_CLR: begin
            pos_count <= '0;
            tex_count <= '0;
            nrm_count <= '0;
            held <= '0;
          end
          default: ;
        endcase
      end
      if (q_push) wp <= wp + CQ_AW'(1);
      if (cmd_pop) rp <= rp + CQ_AW'(1);
      qn <= qn + (CQ_AW+1)'(q_push) - (CQ_AW+1)'(cmd_pop);
    end
  end

  // corner indices and queue entries carry no reset
  always_ff @(posedge clk) begin
    if (accept && item.mode == MODE_TRI && held != 2'd2) begin
      cp[held[0]] <= item.position_number;
      ct[held[0]] <= item.texcoord_number;
      cn[held[0]] <= item.normal_number;
    end
    if (q_push) q[wp] <= ncmd;
  end

endmodule

>>> design/tf_back.sv
// Back end: owns the three tables, runs normal loads through the normalize
// unit and triangle frames through a shared multiplier and the normalize
// unit, and queues results. Depends on tf_pkg, tf_ram and tf_norm.
module tf_back import tf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic empty,
  input  logic pop,
  output out_t result
);

  typedef enum logic [2:0] {
    B_IDLE, B_RD, B_DIFF, B_MUL, B_NORM, B_NRD, B_NCAP, B_EMIT
  } bstate_t;
  typedef enum logic [1:0] {PH_LOAD, PH_BASE, PH_CR1, PH_CR2} phase_t;

  bstate_t          state;
  phase_t           phase;
  cmd_t             cur;
  logic [1:0]       rd;
  logic [2:0]       mstep;
  logic [1:0]       k;
  svec_t            pr [3];
  logic [2:0][31:0] vr;
  svec_t            opa;
  svec_t            opb;
  logic [31:0]      sa;
  logic [31:0]      sb;
  wvec_t            acc;
  logic signed [63:0] prod;
  svec_t            bs;
  svec_t            bt;
  svec_t            tg;
  svec_t            nrm;
  norm_req_t        nreq;

  logic             pos_we, tex_we, nrm_we;
  logic [POS_AW-1:0] pos_raddr;
  logic [TEX_AW-1:0] tex_raddr;
  logic [NRM_AW-1:0] nrm_raddr;
  svec_t            pos_rdata;
  logic [31:0]      tex_rdata;
  svec_t            nrm_rdata;
  logic             ndone;
  svec_t            nres;

  logic signed [31:0] ma;
  logic signed [31:0] mb;
  logic [2:0]       mj;

  out_t             oq [OQ_DEPTH];
  logic [OQ_AW-1:0] owp;
  logic [OQ_AW-1:0] orp;
  logic [OQ_AW:0]   on;
  logic             o_push;
  logic             o_pop;

  assign cmd_pop = (state == B_IDLE) && cmd_valid;
  assign pos_we = cmd_pop && (cmd.op == OP_POS);
  assign tex_we = cmd_pop && (cmd.op == OP_TEX);
  assign nrm_we = (state == B_NORM) && ndone && (phase == PH_LOAD);
  assign o_push = (state == B_EMIT) && (on != (OQ_AW+1)'(OQ_DEPTH));
  assign o_pop = pop && (on != '0);
  assign empty = (on == '0);
  assign result = oq[orp];
  assign mj = mstep - 3'd1;

  always_comb begin
    case (rd)
      2'd1: begin pos_raddr = cur.pidx[1]; tex_raddr = cur.tidx[1]; end
      2'd2: begin pos_raddr = cur.pidx[2]; tex_raddr = cur.tidx[2]; end
      default: begin pos_raddr = cur.pidx[0]; tex_raddr = cur.tidx[0]; end
    endcase
    case (k)
      2'd1: nrm_raddr = cur.nidx[1];
      2'd2: nrm_raddr = cur.nidx[2];
      default: nrm_raddr = cur.nidx[0];
    endcase
  end

  // base: dv31*e21 - dv21*e31; otherwise cross product opa x opb
  always_comb begin
    ma = '0;
    mb = '0;
    if (phase == PH_BASE) begin
      case (mstep)
        3'd0: begin ma = sa; mb = opa[0]; end
        3'd1: begin ma = sb; mb = opb[0]; end
        3'd2: begin ma = sa; mb = opa[1]; end
        3'd3: begin ma = sb; mb = opb[1]; end
        3'd4: begin ma = sa; mb = opa[2]; end
        3'd5: begin ma = sb; mb = opb[2]; end
        default: ;
      endcase
    end else begin
      case (mstep)
        3'd0: begin ma = opa[1]; mb = opb[2]; end
        3'd1: begin ma = opa[2]; mb = opb[1]; end
        3'd2: begin ma = opa[2]; mb = opb[0]; end
        3'd3: begin ma = opa[0]; mb = opb[2]; end
        3'd4: begin ma = opa[0]; mb = opb[1]; end
        3'd5: begin ma = opa[1]; mb = opb[0]; end
        default: ;
      endcase
    end
  end

  tf_ram #(.WIDTH(96), .DEPTH(POS_DEPTH)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(cmd.pidx[0]), .wdata(cmd.vec),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );

  // only v is ever read back from the texcoord table
  tf_ram #(.WIDTH(32), .DEPTH(TEX_DEPTH)) u_tex_ram (
    .clk(clk), .we(tex_we), .waddr(cmd.tidx[0]), .wdata(cmd.vec[1]),
    .raddr(tex_raddr), .rdata(tex_rdata)
  );

  tf_ram #(.WIDTH(96), .DEPTH(NRM_DEPTH)) u_nrm_ram (
    .clk(clk), .we(nrm_we), .waddr(cur.nidx[0]), .wdata(nres),
    .raddr(nrm_raddr), .rdata(nrm_rdata)
  );

  tf_norm u_norm (
    .clk(clk), .rst(rst), .req(nreq), .vec(acc), .done(ndone), .res(nres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      nreq <= '0;
      owp <= '0;
      orp <= '0;
      on <= '0;
    end else begin
      nreq.start <= 1'b0;
      case (state)
        B_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            if (cmd.op == OP_NRM) begin
              for (int i = 0; i < 3; i++) acc[i] <= {{32{cmd.vec[i][31]}}, cmd.vec[i]};
              phase <= PH_LOAD;
              nreq <= '{start: 1'b1, scale_only: 1'b0};
              state <= B_NORM;
            end else if (cmd.op == OP_TRI) begin
              k <= '0;
              rd <= '0;
              if (cmd.geom_ok) begin
                state <= B_RD;
              end else begin
                tg <= '0;
                bt <= '0;
                state <= B_EMIT;
              end
            end
          end
        end
        B_RD: begin
          if (rd != 2'd0) begin
            pr[rd - 2'd1] <= pos_rdata;
            vr[rd - 2'd1] <= tex_rdata;
          end
          rd <= rd + 2'd1;
          if (rd == 2'd3) state <= B_DIFF;
        end
        B_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            opa[i] <= diff31(pr[1][i], pr[0][i]);
            opb[i] <= diff31(pr[2][i], pr[0][i]);
          end
          sa <= diff31(vr[2], vr[0]);
          sb <= diff31(vr[1], vr[0]);
          phase <= PH_BASE;
          mstep <= '0;
          state <= B_MUL;
        end
        B_MUL: begin
          prod <= ma * mb;
          if (mstep != 3'd0) begin
            if (!mj[0]) acc[mj[2:1]] <= prod;
            else acc[mj[2:1]] <= acc[mj[2:1]] - prod;
          end
          mstep <= mstep + 3'd1;
          if (mstep == 3'd6) begin
            nreq <= '{start: 1'b1, scale_only: (phase == PH_BASE)};
            state <= B_NORM;
          end
        end
        B_NORM: begin
          if (ndone) begin
            case (phase)
              PH_LOAD: state <= B_IDLE;
              PH_BASE: begin
                bs <= nres;
                k <= '0;
                state <= B_NRD;
              end
              PH_CR1: begin
                bt <= nres;
                opa <= nres;
                opb <= nrm;
                phase <= PH_CR2;
                mstep <= '0;
                state <= B_MUL;
              end
              default: begin
                tg <= nres;
                state <= B_EMIT;
              end
            endcase
          end
        end
        B_NRD: begin
          if (cur.geom_ok && cur.nok[k]) begin
            state <= B_NCAP;
          end else begin
            tg <= '0;
            bt <= '0;
            state <= B_EMIT;
          end
        end
        B_NCAP: begin
          nrm <= nrm_rdata;
          opa <= nrm_rdata;
          opb <= bs;
          phase <= PH_CR1;
          mstep <= '0;
          state <= B_MUL;
        end
        B_EMIT: begin
          if (o_push) begin
            if (k == 2'd2) begin
              state <= B_IDLE;
            end else begin
              k <= k + 2'd1;
              state <= B_NRD;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
      if (o_push) owp <= owp + OQ_AW'(1);
      if (o_pop) orp <= orp + OQ_AW'(1);
      on <= on + (OQ_AW+1)'(o_push) - (OQ_AW+1)'(o_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (o_push) begin
      oq[owp] <= '{corner: k, last: (k == 2'd2), index_fault: cur.fault,
                   tangent_x: tg[0], tangent_y: tg[1], tangent_z: tg[2],
                   bitangent_x: bt[0], bitangent_y: bt[1], bitangent_z: bt[2]};
    end
  end

endmodule

>>> design/triangle_tangent_frame.sv
// Per-triangle tangent frames in signed Q16.16. Loads of positions and
// texcoords are written from the command queue as they are taken; a normal
// load runs through the normalize unit. A triangle closed by its third
// corner goes through fetch, base-tangent math and a base prescale, plus,
// per corner, two cross products and two normalizations; the 32-step square
// root and 18-step divider of the single normalize unit take most of that
// work. Corner items that do not close a triangle, clears and unused modes
// queue no work for the back end.
// A four-entry command queue decouples intake from the back end, and a
// four-entry result queue holds finished frames. No clearing pass after reset.
// Depends on tf_pkg, tf_front and tf_back.
module triangle_tangent_frame import tf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  item,
  output logic empty,
  input  logic pop,
  output out_t result
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  tf_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  tf_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .empty(empty), .pop(pop), .result(result)
  );

  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("back end took a command from an empty queue");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result queue not empty after reset");

  a_last_on_third: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.last == (result.corner == 2'd2)))
    else $error("last flag does not match corner");

endmodule
